// ===== rtl/tkd_pkg.sv =====
// shared types, widths and command codes for the top-k score keeper
package tkd_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ID_W        = 24;
    localparam int SCORE_W     = 32;
    localparam int K_W         = 5;
    localparam logic [K_W-1:0] K_RESET = K_W'(16);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DUMP   = 1'b1;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_EVICT  = 2'd2;
    localparam logic [1:0] OP_ROTATE = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } entry_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } cmd_t;

endpackage

// ===== rtl/tkd_cell.sv =====
// one cell of the sorted entry chain: holds one entry, trades with its neighbors
module tkd_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  tkd_pkg::cmd_t   cmd,
    input  tkd_pkg::entry_t prev,
    input  tkd_pkg::entry_t next,
    input  tkd_pkg::entry_t head,
    output tkd_pkg::entry_t cur,
    output tkd_pkg::entry_t cur_next,
    output logic            hit
);

    logic                        valid_reg;
    logic [tkd_pkg::ID_W-1:0]    id_reg;
    logic [tkd_pkg::SCORE_W-1:0] score_reg;
    tkd_pkg::entry_t             entry_next;
    tkd_pkg::entry_t             new_entry;
    logic                        own_le;
    logic                        prev_le;
    logic                        prev_gt;
    logic                        next_le;

    assign cur       = '{valid: valid_reg, id: id_reg, score: score_reg};
    assign cur_next  = entry_next;
    assign hit       = valid_reg && (id_reg == cmd.id);
    assign new_entry = '{valid: 1'b1, id: cmd.id, score: cmd.score};

    always_comb
    begin
        own_le  = valid_reg && (score_reg <= cmd.score);
        prev_le = prev.valid && (prev.score <= cmd.score);
        prev_gt = prev.valid && (prev.score > cmd.score);
        next_le = next.valid && (next.score <= cmd.score);
        entry_next = cur;
        unique case (cmd.op)
            tkd_pkg::OP_INSERT:
            begin
                if (own_le)
                    entry_next = cur;
                else if (prev_gt)
                    entry_next = prev;
                else if (prev_le)
                    entry_next = new_entry;
            end
            tkd_pkg::OP_EVICT:
            begin
                if (next_le)
                    entry_next = next;
                else if (own_le)
                    entry_next = new_entry;
            end
            tkd_pkg::OP_ROTATE:
            begin
                if (next.valid)
                    entry_next = next;
                else if (valid_reg)
                    entry_next = head;
            end
            default:
            begin
                entry_next = cur;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= entry_next.valid;
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= entry_next.id;
        score_reg <= entry_next.score;
    end

endmodule

// ===== rtl/tkd_chain.sv =====
// row of entry cells kept in ascending score order, oldest first among ties
module tkd_chain (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tkd_pkg::cmd_t                     cmd,
    output tkd_pkg::entry_t                   head,
    output tkd_pkg::entry_t                   head_next,
    output logic [tkd_pkg::MAX_ENTRIES-1:0]   hit
);

    tkd_pkg::entry_t cur      [tkd_pkg::MAX_ENTRIES];
    tkd_pkg::entry_t cur_next [tkd_pkg::MAX_ENTRIES];
    tkd_pkg::entry_t prev_in  [tkd_pkg::MAX_ENTRIES];
    tkd_pkg::entry_t next_in  [tkd_pkg::MAX_ENTRIES];

    assign head      = cur[0];
    assign head_next = cur_next[0];

    genvar gi;
    generate
        for (gi = 0; gi < tkd_pkg::MAX_ENTRIES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                // lowest possible neighbor so the head always sees its left side as below
                assign prev_in[gi] = '{valid: 1'b1, id: '0, score: '0};
            end
            else
            begin : g_mid
                assign prev_in[gi] = cur[gi-1];
            end

            if (gi == tkd_pkg::MAX_ENTRIES - 1)
            begin : g_last
                assign next_in[gi] = '0;
            end
            else
            begin : g_inner
                assign next_in[gi] = cur[gi+1];
            end

            tkd_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .prev     (prev_in[gi]),
                .next     (next_in[gi]),
                .head     (cur[0]),
                .cur      (cur[gi]),
                .cur_next (cur_next[gi]),
                .hit      (hit[gi])
            );
        end
    endgenerate

endmodule

// ===== rtl/top_k_score_keeper_dedup.sv =====
// top level of the top-k score keeper with duplicate id filter
//
// req channel (req_valid/req_ready) takes one word per request: req_type 0
// inserts record_id with score, req_type 1 dumps the held entries. res
// channel (res_valid/res_ready) returns result words. cfg channel
// (cfg_valid/cfg_ready) writes k_limit and is always ready. the user must
// write k_limit only while idle; the block does not enforce it. an insert is
// settled in the cycle it is accepted: the chain of cells compares every
// held id and score in parallel and shifts in one step, and its result
// word shows on res the next cycle. inserts run at one per cycle while res
// is taken. a dump first loads its entry count, then gives one word per
// cycle in ascending score order by rotating the chain once per word; an
// empty dump gives one word with item_valid low. req_ready stays low for
// the whole dump. reset empties the store and sets k_limit to 16. when
// res_ready is low the result word holds; req_ready and the dump walk stall.
module top_k_score_keeper_dedup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          req_type,
    input  logic [tkd_pkg::ID_W-1:0]      record_id,
    input  logic [tkd_pkg::SCORE_W-1:0]   score,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tkd_pkg::K_W-1:0]       cfg_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          accepted,
    output logic                          evicted_valid,
    output logic [tkd_pkg::ID_W-1:0]      evicted_id,
    output logic [tkd_pkg::SCORE_W-1:0]   min_score,
    output logic                          full_res,
    output logic                          item_valid,
    output logic [tkd_pkg::ID_W-1:0]      item_id,
    output logic [tkd_pkg::SCORE_W-1:0]   item_score,
    output logic                          last
);

    localparam int CW = tkd_pkg::CNT_W;

    logic [tkd_pkg::K_W-1:0]        k_limit_reg;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;
    logic [CW-1:0]                  dump_left_reg;
    logic [CW-1:0]                  dump_left_next;
    logic [CW-1:0]                  k_eff;
    logic                           busy;
    logic                           slot_free;
    logic                           req_fire;
    logic                           dump_step;
    logic                           dup;
    logic                           res_valid_reg;
    logic                           res_valid_next;
    logic                           load_res;

    logic                           accepted_reg, accepted_next;
    logic                           evicted_valid_reg, evicted_valid_next;
    logic [tkd_pkg::ID_W-1:0]       evicted_id_reg, evicted_id_next;
    logic [tkd_pkg::SCORE_W-1:0]    min_score_reg, min_score_next;
    logic                           full_res_reg, full_res_next;
    logic                           item_valid_reg, item_valid_next;
    logic [tkd_pkg::ID_W-1:0]       item_id_reg, item_id_next;
    logic [tkd_pkg::SCORE_W-1:0]    item_score_reg, item_score_next;
    logic                           last_reg, last_next;

    tkd_pkg::cmd_t                  cmd;
    tkd_pkg::entry_t                head;
    tkd_pkg::entry_t                head_next;
    logic [tkd_pkg::MAX_ENTRIES-1:0] hit;

    tkd_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .head      (head),
        .head_next (head_next),
        .hit       (hit)
    );

    assign cfg_ready = 1'b1;
    assign busy      = (dump_left_reg != '0);
    assign slot_free = !res_valid_reg || res_ready;
    assign req_ready = !busy && slot_free;
    assign req_fire  = req_valid && req_ready;
    assign dump_step = busy && slot_free;
    assign dup       = |hit;

    always_comb
    begin
        if (k_limit_reg == '0)
            k_eff = CW'(1);
        else if (32'(k_limit_reg) > 32'(tkd_pkg::MAX_ENTRIES))
            k_eff = CW'(tkd_pkg::MAX_ENTRIES);
        else
            k_eff = CW'(k_limit_reg);
    end

    always_comb
    begin
        cmd            = '{op: tkd_pkg::OP_HOLD, id: record_id, score: score};
        count_next     = count_reg;
        dump_left_next = dump_left_reg;
        load_res       = 1'b0;
        res_valid_next = res_valid_reg && !res_ready;

        accepted_next      = 1'b0;
        evicted_valid_next = 1'b0;
        evicted_id_next    = '0;
        min_score_next     = '0;
        full_res_next      = 1'b0;
        item_valid_next    = 1'b0;
        item_id_next       = '0;
        item_score_next    = '0;
        last_next          = 1'b1;

        if (req_fire && req_type == tkd_pkg::REQ_INSERT)
        begin
            if (!dup && count_reg < k_eff)
            begin
                cmd.op        = tkd_pkg::OP_INSERT;
                count_next    = count_reg + CW'(1);
                accepted_next = 1'b1;
            end
            else if (!dup && head.valid && score > head.score)
            begin
                cmd.op             = tkd_pkg::OP_EVICT;
                accepted_next      = 1'b1;
                evicted_valid_next = 1'b1;
                evicted_id_next    = head.id;
            end
            min_score_next = head_next.valid ? head_next.score : '0;
            full_res_next  = (count_next >= k_eff);
            load_res       = 1'b1;
        end
        else if (req_fire)
        begin
            if (count_reg == '0)
            begin
                full_res_next = (count_reg >= k_eff);
                load_res      = 1'b1;
            end
            else
            begin
                dump_left_next = count_reg;
            end
        end
        else if (dump_step)
        begin
            cmd.op          = tkd_pkg::OP_ROTATE;
            dump_left_next  = dump_left_reg - CW'(1);
            full_res_next   = (count_reg >= k_eff);
            item_valid_next = 1'b1;
            item_id_next    = head.id;
            item_score_next = head.score;
            last_next       = (dump_left_reg == CW'(1));
            load_res        = 1'b1;
        end

        if (load_res)
            res_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_limit_reg   <= tkd_pkg::K_RESET;
            count_reg     <= '0;
            dump_left_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                k_limit_reg <= cfg_data;
            count_reg     <= count_next;
            dump_left_reg <= dump_left_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            accepted_reg      <= accepted_next;
            evicted_valid_reg <= evicted_valid_next;
            evicted_id_reg    <= evicted_id_next;
            min_score_reg     <= min_score_next;
            full_res_reg      <= full_res_next;
            item_valid_reg    <= item_valid_next;
            item_id_reg       <= item_id_next;
            item_score_reg    <= item_score_next;
            last_reg          <= last_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign accepted      = accepted_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_id    = evicted_id_reg;
    assign min_score     = min_score_reg;
    assign full_res      = full_res_reg;
    assign item_valid    = item_valid_reg;
    assign item_id       = item_id_reg;
    assign item_score    = item_score_reg;
    assign last          = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= tkd_pkg::MAX_ENTRIES)
        else $error("held count above capacity");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> head.valid)
        else $error("chain head empty while entries held");

    a_dump_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !last) |-> busy)
        else $error("dump stopped before its last word");

    a_evict_implies_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && evicted_valid) |-> accepted)
        else $error("eviction without acceptance");

endmodule

// ===== tb/tkd_checker.sv =====
// checker for the top-k score keeper: predicts result words and compares them
module tkd_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  logic                        req_type,
    input  logic [tkd_pkg::ID_W-1:0]    record_id,
    input  logic [tkd_pkg::SCORE_W-1:0] score,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [tkd_pkg::K_W-1:0]     cfg_data,
    input  logic                        res_valid,
    input  logic                        res_ready,
    input  logic                        accepted,
    input  logic                        evicted_valid,
    input  logic [tkd_pkg::ID_W-1:0]    evicted_id,
    input  logic [tkd_pkg::SCORE_W-1:0] min_score,
    input  logic                        full_res,
    input  logic                        item_valid,
    input  logic [tkd_pkg::ID_W-1:0]    item_id,
    input  logic [tkd_pkg::SCORE_W-1:0] item_score,
    input  logic                        last,
    output int                          fail_count,
    output int                          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        acc;
        logic                        ev;
        logic [tkd_pkg::ID_W-1:0]    ev_id;
        logic [tkd_pkg::SCORE_W-1:0] min_sc;
        logic                        full;
        logic                        iv;
        logic [tkd_pkg::ID_W-1:0]    i_id;
        logic [tkd_pkg::SCORE_W-1:0] i_sc;
        logic                        lst;
    } res_word_t;

    res_word_t                   expected_words[$];
    logic [tkd_pkg::ID_W-1:0]    held_ids[tkd_pkg::MAX_ENTRIES];
    logic [tkd_pkg::SCORE_W-1:0] held_scores[tkd_pkg::MAX_ENTRIES];
    int                          held_n;
    logic [tkd_pkg::K_W-1:0]     k_reg;

    function automatic int capacity();
        int k;
        k = int'(k_reg);
        if (k < 1) k = 1;
        if (k > tkd_pkg::MAX_ENTRIES) k = tkd_pkg::MAX_ENTRIES;
        return k;
    endfunction

    // lowest score, oldest wins ties
    function automatic int lowest_slot();
        int m;
        m = 0;
        for (int i = 1; i < held_n; i++)
            if (held_scores[i] < held_scores[m]) m = i;
        return m;
    endfunction

    task automatic predict_insert(input logic [tkd_pkg::ID_W-1:0] id,
                                  input logic [tkd_pkg::SCORE_W-1:0] sc);
        res_word_t w;
        logic      dup;
        int        cap;
        int        m;
        w   = '0;
        dup = 1'b0;
        cap = capacity();
        for (int i = 0; i < held_n; i++)
            if (held_ids[i] == id) dup = 1'b1;
        if (!dup) begin
            if (held_n < cap) begin
                w.acc = 1'b1;
            end
            else if (held_n > 0) begin
                m = lowest_slot();
                if (sc > held_scores[m]) begin
                    w.acc   = 1'b1;
                    w.ev    = 1'b1;
                    w.ev_id = held_ids[m];
                    for (int i = m; i + 1 < held_n; i++) begin
                        held_ids[i]    = held_ids[i+1];
                        held_scores[i] = held_scores[i+1];
                    end
                    held_n--;
                end
            end
            if (w.acc && held_n < tkd_pkg::MAX_ENTRIES) begin
                held_ids[held_n]    = id;
                held_scores[held_n] = sc;
                held_n++;
            end
        end
        if (held_n > 0) w.min_sc = held_scores[lowest_slot()];
        w.full = (held_n >= cap);
        w.lst  = 1'b1;
        expected_words = {expected_words, w};
    endtask

    task automatic predict_dump();
        res_word_t ranked[tkd_pkg::MAX_ENTRIES];
        res_word_t w;
        int        rank;
        int        cap;
        cap = capacity();
        if (held_n == 0) begin
            w     = '0;
            w.lst = 1'b1;
            expected_words = {expected_words, w};
        end
        else begin
            for (int i = 0; i < held_n; i++) begin
                rank = 0;
                for (int j = 0; j < held_n; j++)
                    if (held_scores[j] < held_scores[i] ||
                        (held_scores[j] == held_scores[i] && j < i))
                        rank++;
                w      = '0;
                w.full = (held_n >= cap);
                w.iv   = 1'b1;
                w.i_id = held_ids[i];
                w.i_sc = held_scores[i];
                w.lst  = (rank + 1 == held_n);
                ranked[rank] = w;
            end
            for (int i = 0; i < held_n; i++) expected_words = {expected_words, ranked[i]};
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        res_word_t w;
        if (!rst_n) begin
            expected_words.delete();
            held_n        = 0;
            k_reg         = tkd_pkg::K_RESET;
            fail_count    = 0;
            pending_count <= 0;
        end
        else begin
            if (res_valid && res_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else begin
                    w = expected_words.pop_front();
                    compare_field("accepted", 32'(w.acc), 32'(accepted));
                    compare_field("evicted_valid", 32'(w.ev), 32'(evicted_valid));
                    compare_field("evicted_id", 32'(w.ev_id), 32'(evicted_id));
                    compare_field("min_score", w.min_sc, min_score);
                    compare_field("full_res", 32'(w.full), 32'(full_res));
                    compare_field("item_valid", 32'(w.iv), 32'(item_valid));
                    compare_field("item_id", 32'(w.i_id), 32'(item_id));
                    compare_field("item_score", w.i_sc, item_score);
                    compare_field("last", 32'(w.lst), 32'(last));
                end
            end
            if (cfg_valid && cfg_ready) k_reg = cfg_data;
            if (req_valid && req_ready) begin
                if (req_type == tkd_pkg::REQ_DUMP) predict_dump();
                else predict_insert(record_id, score);
            end
            pending_count <= expected_words.size();
        end
    end

endmodule

// ===== tb/top_k_score_keeper_dedup_test.sv =====
// testbench top for the top-k score keeper: clock, reset, stimulus and verdict
module top_k_score_keeper_dedup_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;

    logic                        clk;
    logic                        rst_n;
    logic                        req_valid;
    logic                        req_ready;
    logic                        req_type;
    logic [tkd_pkg::ID_W-1:0]    record_id;
    logic [tkd_pkg::SCORE_W-1:0] score;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [tkd_pkg::K_W-1:0]     cfg_data;
    logic                        res_valid;
    logic                        res_ready;
    logic                        accepted;
    logic                        evicted_valid;
    logic [tkd_pkg::ID_W-1:0]    evicted_id;
    logic [tkd_pkg::SCORE_W-1:0] min_score;
    logic                        full_res;
    logic                        item_valid;
    logic [tkd_pkg::ID_W-1:0]    item_id;
    logic [tkd_pkg::SCORE_W-1:0] item_score;
    logic                        last;

    int                          fail_count;
    int                          pending_count;
    int                          burst_left;
    int                          idle_cycles;
    logic                        squeeze;

    top_k_score_keeper_dedup dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
        .record_id(record_id), .score(score),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .res_valid(res_valid), .res_ready(res_ready),
        .accepted(accepted), .evicted_valid(evicted_valid), .evicted_id(evicted_id),
        .min_score(min_score), .full_res(full_res), .item_valid(item_valid),
        .item_id(item_id), .item_score(item_score), .last(last)
    );

    tkd_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
        .record_id(record_id), .score(score),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .res_valid(res_valid), .res_ready(res_ready),
        .accepted(accepted), .evicted_valid(evicted_valid), .evicted_id(evicted_id),
        .min_score(min_score), .full_res(full_res), .item_valid(item_valid),
        .item_id(item_id), .item_score(item_score), .last(last),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (res_valid && res_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end
        else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver: stall pattern steps through four settings in turn, one long hold on request
    initial begin
        int cyc;
        int hold_left;
        logic squeezed;
        cyc       = 0;
        hold_left = 0;
        squeezed  = 1'b0;
        res_ready = 1'b0;
        forever begin
            @(negedge clk);
            cyc++;
            if (hold_left > 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (squeeze && !squeezed) begin
                squeezed  = 1'b1;
                hold_left = 150;
                res_ready <= 1'b0;
            end
            else begin
                case ((cyc / 48) % 4)
                    0:       res_ready <= 1'b1;
                    1:       res_ready <= 1'($urandom_range(0, 1));
                    2:       res_ready <= ($urandom_range(0, 4) != 0);
                    default: res_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_req(input logic t, input logic [tkd_pkg::ID_W-1:0] id,
                            input logic [tkd_pkg::SCORE_W-1:0] sc);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req_type  <= t;
        record_id <= id;
        score     <= sc;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [tkd_pkg::K_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic insert_word(input logic [tkd_pkg::ID_W-1:0] id,
                               input logic [tkd_pkg::SCORE_W-1:0] sc);
        send_req(tkd_pkg::REQ_INSERT, id, sc);
    endtask

    task automatic dump_word();
        send_req(tkd_pkg::REQ_DUMP, tkd_pkg::ID_W'($urandom), $urandom);
    endtask

    initial begin
        logic [tkd_pkg::K_W-1:0]     caps[6];
        logic [tkd_pkg::ID_W-1:0]    id;
        logic [tkd_pkg::SCORE_W-1:0] sc;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_type   = tkd_pkg::REQ_INSERT;
        record_id  = '0;
        score      = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        burst_left = 0;
        squeeze    = 1'b0;
        caps       = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd3, 5'd0};
        caps[2]    = tkd_pkg::K_W'($urandom_range(2, 15));
        caps[5]    = tkd_pkg::K_W'($urandom_range(0, 31));
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty store, extremes, duplicate id, equal minima
        dump_word();
        insert_word('0, '0);
        insert_word('1, '1);
        insert_word('0, 32'd5);
        insert_word(24'd5, '0);
        dump_word();
        drain();

        // capacity below held count, oldest of equal minima evicted
        write_capacity(5'd2);
        insert_word(24'd7, '0);
        insert_word(24'd8, 32'd100);
        dump_word();
        drain();

        // zero capacity acts as one
        write_capacity(5'd0);
        insert_word(24'd9, 32'd50);
        dump_word();
        drain();

        // capacity above the store size, add twelve new ids and dump
        write_capacity(5'd31);
        for (int i = 0; i < 12; i++)
            insert_word(tkd_pkg::ID_W'(100 + i), tkd_pkg::SCORE_W'((i + 1) << 20));
        dump_word();
        drain();

        for (int p = 0; p < 6; p++) begin
            write_capacity(caps[p]);
            if (p == 0) squeeze = 1'b1;
            for (int n = 0; n < 16; n++) begin
                if ($urandom_range(0, 5) == 0) begin
                    dump_word();
                end
                else begin
                    id = ($urandom_range(0, 3) != 0) ?
                         tkd_pkg::ID_W'($urandom_range(0, 23)) : tkd_pkg::ID_W'($urandom);
                    sc = ($urandom_range(0, 2) == 0) ?
                         tkd_pkg::SCORE_W'($urandom_range(0, 3) << 16) : $urandom;
                    insert_word(id, sc);
                end
            end
            drain();
        end

        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("TB_OK");
        end
        else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tkd_pkg.sv
rtl/tkd_cell.sv
rtl/tkd_chain.sv
rtl/top_k_score_keeper_dedup.sv
tb/tkd_checker.sv
tb/top_k_score_keeper_dedup_test.sv
